>>> hdl/fpct_pkg.sv
// package: payload types, status codes and defaults for the flow counter table
`default_nettype none
package fpct_pkg;

  localparam int unsigned FLOW_ENTRIES_DEF    = 1024;
  localparam int unsigned BYTE_COUNT_BITS_DEF = 48;
  localparam int unsigned KEY_BITS            = 64;
  localparam int unsigned PKT_BITS            = 32;
  localparam int unsigned TALLY_BITS          = 11;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DRAINED = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] frame_length;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [31:0]           out_src_ip;
    logic [31:0]           out_dst_ip;
    logic [31:0]           out_packets;
    logic [47:0]           out_bytes;
    logic                  last_entry;
    logic [TALLY_BITS-1:0] drained_count;
  } out_beat_t;

endpackage
`default_nettype wire

>>> hdl/ip_pair_flow_counter_table_unit.sv
// Drain and empty answers are registered from the drain or empty state once the output
// register is free; an account probes held entries from the oldest up to the hit, or all
// held entries and then the miss state on a miss. One beat is in flight; the linear probe
// of the entry memory (one write port, one registered read port) reads one slot a cycle
// while the output register is free; a new beat is taken once the state is idle again.
// Reset: synchronous active low; table comes up empty, no clearing pass, memory undefined.
`default_nettype none
module ip_pair_flow_counter_table_unit #(
  parameter int unsigned FLOW_ENTRIES    = fpct_pkg::FLOW_ENTRIES_DEF,
  parameter int unsigned BYTE_COUNT_BITS = fpct_pkg::BYTE_COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpct_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fpct_pkg::out_beat_t     out_data
);

  import fpct_pkg::*;

  localparam int unsigned SLOT_W = $clog2(FLOW_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(FLOW_ENTRIES + 1);
  localparam int unsigned DW     = KEY_BITS + PKT_BITS + BYTE_COUNT_BITS;
  localparam logic [CNT_W-1:0]  ENTRIES_C  = CNT_W'(FLOW_ENTRIES);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(FLOW_ENTRIES - 1);
  localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MISS  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMPTY = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [SLOT_W-1:0]     oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [TALLY_BITS-1:0] tally_r, tally_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      probe_r, probe_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [15:0]           len_r;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_r, out_nxt;

  logic                  we;
  logic [SLOT_W-1:0]     waddr, raddr;
  logic [DW-1:0]         wdata, rdata;

  logic [KEY_BITS-1:0]        rd_key;
  logic [PKT_BITS-1:0]        rd_pkt, pkt_inc;
  logic [BYTE_COUNT_BITS-1:0] rd_bytes, bytes_add;
  logic [BYTE_COUNT_BITS:0]   bytes_sum;
  logic                       out_free, hit;
  logic [SLOT_W-1:0]          slot_next, oldest_next;
  logic [CNT_W:0]             tail_sum;
  logic [SLOT_W-1:0]          tail_slot;
  logic [TALLY_BITS-1:0]      tally_inc;

  fpct_mem #(
    .DEPTH(FLOW_ENTRIES),
    .AW   (SLOT_W),
    .DW   (DW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_key   = rdata[DW-1 -: KEY_BITS];
  assign rd_pkt   = rdata[BYTE_COUNT_BITS +: PKT_BITS];
  assign rd_bytes = rdata[BYTE_COUNT_BITS-1:0];
  assign pkt_inc  = (rd_pkt == '1) ? rd_pkt : rd_pkt + PKT_BITS'(1);
  assign bytes_sum = {1'b0, rd_bytes} + (BYTE_COUNT_BITS + 1)'(len_r);
  assign bytes_add = bytes_sum[BYTE_COUNT_BITS] ? '1 : bytes_sum[BYTE_COUNT_BITS-1:0];
  assign hit       = (rd_key == key_r);
  assign out_free  = !out_valid_r || out_ready;
  assign slot_next   = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
  assign oldest_next = (oldest_r == LAST_SLOT) ? '0 : oldest_r + SLOT_W'(1);
  // ring tail, count is below the depth whenever it is used
  assign tail_sum  = (CNT_W + 1)'(oldest_r) + (CNT_W + 1)'(count_r);
  assign tail_slot = (tail_sum >= (CNT_W + 1)'(FLOW_ENTRIES))
                     ? SLOT_W'(tail_sum - (CNT_W + 1)'(FLOW_ENTRIES))
                     : SLOT_W'(tail_sum);
  assign tally_inc = (tally_r == TALLY_MAX) ? tally_r : tally_r + TALLY_BITS'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    tally_nxt     = tally_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = slot_r;
    wdata         = {key_r, pkt_inc, bytes_add};
    raddr         = slot_r;
    unique case (state_r)
      S_IDLE: begin
        raddr = oldest_r;
        if (in_valid) begin
          slot_nxt  = oldest_r;
          probe_nxt = '0;
          if (in_data.operation == OP_DRAIN) begin
            state_nxt = (count_r == '0) ? S_EMPTY : S_DRAIN;
          end else begin
            state_nxt = (count_r == '0) ? S_MISS : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (hit) begin
            we            = 1'b1;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.status      = ST_UPDATED;
            out_nxt.out_packets = pkt_inc;
            out_nxt.out_bytes   = 48'(bytes_add);
            state_nxt     = S_IDLE;
          end else if (probe_r == count_r - CNT_W'(1)) begin
            state_nxt = S_MISS;
          end else begin
            raddr     = slot_next;
            slot_nxt  = slot_next;
            probe_nxt = probe_r + CNT_W'(1);
          end
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = S_IDLE;
          if (count_r >= ENTRIES_C) begin
            out_nxt.status = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = tail_slot;
            wdata     = {key_r, PKT_BITS'(1), BYTE_COUNT_BITS'(len_r)};
            count_nxt = count_r + CNT_W'(1);
            out_nxt.status      = ST_NEW;
            out_nxt.out_packets = PKT_BITS'(1);
            out_nxt.out_bytes   = 48'(len_r);
          end
        end
      end
      S_DRAIN: begin
        raddr = oldest_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.status        = ST_DRAINED;
          out_nxt.out_src_ip    = rd_key[63:32];
          out_nxt.out_dst_ip    = rd_key[31:0];
          out_nxt.out_packets   = rd_pkt;
          out_nxt.out_bytes     = 48'(rd_bytes);
          out_nxt.last_entry    = (count_r == CNT_W'(1));
          out_nxt.drained_count = tally_inc;
          tally_nxt  = (count_r == CNT_W'(1)) ? '0 : tally_inc;
          oldest_nxt = oldest_next;
          count_nxt  = count_r - CNT_W'(1);
          state_nxt  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = ST_EMPTY;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    probe_r <= probe_nxt;
    out_r   <= out_nxt;
    if (in_valid && in_ready) begin
      key_r <= {in_data.src_ip, in_data.dst_ip};
      len_r <= in_data.frame_length;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ENTRIES_C)
    else $error("entry count above table depth");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (probe_r < count_r))
    else $error("probe beyond held entries");

  a_last_clears_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && out_free && count_r == CNT_W'(1)) |=> (tally_r == '0))
    else $error("drain tally not cleared after last entry");

  a_write_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> out_valid_r)
    else $error("memory write without a result");
`endif

endmodule
`default_nettype wire

>>> hdl/fpct_mem.sv
// flow entry memory: one write port, one registered read port
`default_nettype none
module fpct_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 144
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
